// File: design/mid_pkg.sv
// Shared types, constants and the Morse letter table for the interval decoder.
// No dependencies; every other design file imports this package.
package mid_pkg;

  localparam int MAX_SYMBOLS_DEF = 8;
  localparam int TIME_WIDTH_DEF  = 32;

  localparam int PULSE_W  = 32;
  localparam int THR_W    = 16;
  localparam int CHAR_W   = 7;
  localparam int CFG_IDX_W = 8;
  localparam int QDEPTH   = 2;
  localparam int NLETTERS = 26;

  localparam logic [CHAR_W-1:0] CH_UNKNOWN = 7'd63;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 7'd32;
  localparam logic [CHAR_W-1:0] CH_A       = 7'd65;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DOT_MIN    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DASH_MIN   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LETTER_MIN = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_MIN   = 8'd3;

  localparam logic [THR_W-1:0] DOT_MIN_RST    = 16'd1;
  localparam logic [THR_W-1:0] DASH_MIN_RST   = 16'd2;
  localparam logic [THR_W-1:0] LETTER_MIN_RST = 16'd3;
  localparam logic [THR_W-1:0] WORD_MIN_RST   = 16'd4;

  // Letter table: symbol count and pattern (bit i is symbol i, 1 = dash).
  localparam logic [2:0] CODE_LEN [NLETTERS] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };
  localparam logic [3:0] CODE_PAT [NLETTERS] = '{
    4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
    4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
  };

  typedef enum logic [2:0] {
    GAP_NONE,
    GAP_DOT,
    GAP_DASH,
    GAP_LETTER,
    GAP_WORD
  } gap_class_t;

  typedef struct packed {
    logic [THR_W-1:0] dot_min;
    logic [THR_W-1:0] dash_min;
    logic [THR_W-1:0] letter_min;
    logic [THR_W-1:0] word_min;
  } mid_thr_t;

  // One queued job for the output side: an optional letter, an optional space.
  typedef struct packed {
    logic              has_char;
    logic [CHAR_W-1:0] char_code;
    logic              has_space;
  } mid_entry_t;

endpackage

// File: design/mid_front.sv
// Front end: accepts pulses, measures gaps, keeps the symbol register, decodes.
// Depends on mid_pkg; pushes output jobs into mid_queue.
module mid_front
  import mid_pkg::*;
#(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [PULSE_W-1:0] pulse_time,
  input  mid_thr_t           thr,
  output logic               push,
  output mid_entry_t         push_entry
);

  localparam int CW = $clog2(MAX_SYMBOLS + 1);
  localparam int GW = (TIME_WIDTH > THR_W) ? TIME_WIDTH : THR_W;

  logic                   started_r, started_nxt;
  logic [TIME_WIDTH-1:0]  prev_r, prev_nxt;
  logic [MAX_SYMBOLS-1:0] bits_r, bits_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   ovf_r, ovf_nxt;

  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] gap;
  logic [GW-1:0]         gap_x;
  gap_class_t            cls;
  logic [CHAR_W-1:0]     letter;
  logic                  nonempty;
  logic                  is_dash;

  assign now   = TIME_WIDTH'(pulse_time);
  assign gap   = now - prev_r;
  assign gap_x = GW'(gap);

  always_comb begin
    priority if (gap_x >= GW'(thr.dot_min) && gap_x < GW'(thr.dash_min)) begin
      cls = GAP_DOT;
    end else if (gap_x >= GW'(thr.dash_min) && gap_x < GW'(thr.letter_min)) begin
      cls = GAP_DASH;
    end else if (gap_x >= GW'(thr.letter_min) && gap_x < GW'(thr.word_min)) begin
      cls = GAP_LETTER;
    end else if (gap_x >= GW'(thr.word_min)) begin
      cls = GAP_WORD;
    end else begin
      cls = GAP_NONE;
    end
  end

  // Table lookup; bits above the count are always zero, so a full compare works.
  always_comb begin
    letter = CH_UNKNOWN;
    if (!ovf_r) begin
      for (int i = NLETTERS - 1; i >= 0; i--) begin
        if (count_r == CW'(CODE_LEN[i]) && bits_r == MAX_SYMBOLS'(CODE_PAT[i])) begin
          letter = CH_A + CHAR_W'(i);
        end
      end
    end
  end

  assign nonempty = (count_r != '0) || ovf_r;
  assign is_dash  = (cls == GAP_DASH);

  always_comb begin
    started_nxt = started_r;
    prev_nxt    = prev_r;
    bits_nxt    = bits_r;
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    push        = 1'b0;
    push_entry  = '{has_char: nonempty, char_code: letter, has_space: 1'b0};
    if (accept) begin
      prev_nxt    = now;
      started_nxt = 1'b1;
      if (started_r) begin
        unique case (cls)
          GAP_DOT, GAP_DASH: begin
            if (count_r >= CW'(MAX_SYMBOLS)) begin
              ovf_nxt = 1'b1;
            end else begin
              bits_nxt  = bits_r | (MAX_SYMBOLS'(is_dash) << count_r);
              count_nxt = count_r + CW'(1);
            end
          end
          GAP_LETTER, GAP_WORD: begin
            bits_nxt  = '0;
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            push_entry.has_space = (cls == GAP_WORD);
            push = nonempty || (cls == GAP_WORD);
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      bits_r    <= '0;
      count_r   <= '0;
      ovf_r     <= 1'b0;
    end else begin
      started_r <= started_nxt;
      bits_r    <= bits_nxt;
      count_r   <= count_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
  end

endmodule

// File: design/mid_queue.sv
// Short job queue between the front end and the output side.
// Depends on mid_pkg for the entry type and depth.
module mid_queue
  import mid_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  mid_entry_t push_entry,
  input  logic       pop,
  output logic       full,
  output logic       not_empty,
  output mid_entry_t head
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  mid_entry_t    slots_r [QDEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == NW'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slots_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(QDEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(QDEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_r] <= push_entry;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NW'(QDEPTH))
    else $error("queue count exceeds depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from an empty queue");
`endif

endmodule

// File: design/mid_back.sv
// Output side: turns queued jobs into words on the result channel.
// Depends on mid_pkg; reads jobs from mid_queue.
module mid_back
  import mid_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  mid_entry_t        q_head,
  output logic              q_pop,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [CHAR_W-1:0] out_char_code,
  output logic              out_last
);

  logic              valid_r, valid_nxt;
  logic              pend_r, pend_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              last_r, last_nxt;
  logic              load;

  assign load = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    pend_nxt  = pend_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    if (load) begin
      priority if (pend_r) begin
        valid_nxt = 1'b1;
        char_nxt  = CH_SPACE;
        last_nxt  = 1'b1;
        pend_nxt  = 1'b0;
      end else if (q_not_empty) begin
        q_pop     = 1'b1;
        valid_nxt = 1'b1;
        if (q_head.has_char) begin
          char_nxt = q_head.char_code;
          last_nxt = !q_head.has_space;
          pend_nxt = q_head.has_space;
        end else begin
          char_nxt = CH_SPACE;
          last_nxt = 1'b1;
        end
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_valid     = valid_r;
  assign out_char_code = char_r;
  assign out_last      = last_r;

endmodule

// File: design/morse_interval_decoder.sv
// Top level of the Morse interval decoder: configuration registers and wiring.
// Depends on mid_pkg, mid_front, mid_queue and mid_back.

// Each input word is one pulse timestamp in ticks. The first pulse after reset
// only records its time; every later pulse measures the wrapping gap since the
// previous one and classifies it against the four thresholds, which must be
// written while the block is idle. Dot and dash gaps collect symbols; a letter
// gap emits the decoded letter, if any symbols were collected (or '?' for an
// unknown or overflowed pattern), and a word gap emits that letter and then a
// space; the last result word of a pulse carries out_last. The front end can
// accept a new pulse every cycle while the two-entry job queue has room. The
// result port moves one word per cycle while out_stall is low, so a pulse that
// ends a word occupies it for two result words; that single output register
// sets the sustained rate. An accepted pulse reaches its first result word
// through the job queue and then the output register.
module morse_interval_decoder
  import mid_pkg::*;
#(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PULSE_W-1:0]   in_pulse_time,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CHAR_W-1:0]    out_char_code,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data
);

  mid_thr_t   thr_r, thr_nxt;
  logic       accept;
  logic       q_push, q_pop, q_full, q_not_empty;
  mid_entry_t q_in, q_head;

  // The threshold registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  always_comb begin
    thr_nxt = thr_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DOT_MIN:    thr_nxt.dot_min    = cfg_data;
        REG_DASH_MIN:   thr_nxt.dash_min   = cfg_data;
        REG_LETTER_MIN: thr_nxt.letter_min = cfg_data;
        REG_WORD_MIN:   thr_nxt.word_min   = cfg_data;
        default: begin
          // Writes to unknown indexes are dropped.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '{dot_min: DOT_MIN_RST, dash_min: DASH_MIN_RST,
                 letter_min: LETTER_MIN_RST, word_min: WORD_MIN_RST};
    end else begin
      thr_r <= thr_nxt;
    end
  end

  // A pulse is held off only when the job queue has no free entry.
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  mid_front #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .pulse_time (in_pulse_time),
    .thr        (thr_r),
    .push       (q_push),
    .push_entry (q_in)
  );

  mid_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  mid_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

`ifndef SYNTH
  // The front end never pushes into a full queue, since a full queue stalls input.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");
  // A space is always the final word of its pulse.
  a_space_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_char_code == CH_SPACE) |-> out_last)
    else $error("space word without last");
  // A letter that is not last is followed at once by its space.
  a_space_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=>
      (out_valid && out_char_code == CH_SPACE && out_last))
    else $error("letter of a word end not followed by a space");
`endif

endmodule

// File: tb/morse_interval_decoder_test.sv
// Self-checking testbench for morse_interval_decoder: pulses, threshold writes, result words.
// Depends on mid_pkg and the decoder RTL; keeps its own model of the gap classes and table.
module morse_interval_decoder_test
  import mid_pkg::*;
;

  // One expected or observed result word.
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } char_word_t;

  typedef enum {
    STALL_NONE,
    STALL_RANDOM,
    STALL_LONG,
    STALL_TOGGLE
  } stall_mode_t;

  // Keeps a private copy of the decoder state, predicts the characters that
  // each accepted pulse releases, and checks arriving words against them in
  // order.
  class morse_char_checker;
    mid_thr_t          thr;
    logic [31:0]       prev_time;
    bit                started;
    logic [7:0]        sym_bits;
    logic [3:0]        sym_count;
    bit                overflowed;
    char_word_t        due_chars[$];
    int unsigned       errors;
    int unsigned       letters_seen;
    int unsigned       unknown_seen;
    int unsigned       spaces_seen;

    function new();
      thr = '{dot_min: 16'd1, dash_min: 16'd2, letter_min: 16'd3, word_min: 16'd4};
      prev_time = '0;
      started = 0;
      sym_bits = '0;
      sym_count = '0;
      overflowed = 0;
      errors = 0;
      letters_seen = 0;
      unknown_seen = 0;
      spaces_seen = 0;
    endfunction

    // International Morse code for A to Z.
    static function string morse_of(int idx);
      case (idx)
        0: return ".-";
        1: return "-...";
        2: return "-.-.";
        3: return "-..";
        4: return ".";
        5: return "..-.";
        6: return "--.";
        7: return "....";
        8: return "..";
        9: return ".---";
        10: return "-.-";
        11: return ".-..";
        12: return "--";
        13: return "-.";
        14: return "---";
        15: return ".--.";
        16: return "--.-";
        17: return ".-.";
        18: return "...";
        19: return "-";
        20: return "..-";
        21: return "...-";
        22: return ".--";
        23: return "-..-";
        24: return "-.--";
        25: return "--..";
        default: return "";
      endcase
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] val);
      case (idx)
        REG_DOT_MIN: thr.dot_min = val;
        REG_DASH_MIN: thr.dash_min = val;
        REG_LETTER_MIN: thr.letter_min = val;
        REG_WORD_MIN: thr.word_min = val;
        default: ;
      endcase
    endfunction

    function void add_symbol(bit dash);
      if (sym_count >= 4'(MAX_SYMBOLS_DEF)) begin
        overflowed = 1;
      end else begin
        sym_bits[sym_count[2:0]] = dash;
        sym_count++;
      end
    endfunction

    // Looks the collected symbols up in the table and empties the register.
    function logic [CHAR_W-1:0] take_letter();
      string pattern;
      logic [CHAR_W-1:0] ch;
      pattern = "";
      ch = CH_UNKNOWN;
      if (!overflowed) begin
        for (int i = 0; i < int'(sym_count); i++) begin
          if (sym_bits[i]) pattern = {pattern, "-"};
          else pattern = {pattern, "."};
        end
        for (int n = 0; n < NLETTERS; n++) begin
          if (morse_of(n) == pattern) ch = CH_A + CHAR_W'(n);
        end
      end
      sym_bits = '0;
      sym_count = '0;
      overflowed = 0;
      return ch;
    endfunction

    function void note_pulse(logic [31:0] now);
      logic [31:0] gap;
      bit has_letter;
      if (!started) begin
        started = 1;
        prev_time = now;
        return;
      end
      gap = now - prev_time;
      prev_time = now;
      has_letter = (sym_count != 0) || overflowed;
      if (gap >= thr.dot_min && gap < thr.dash_min) begin
        add_symbol(0);
      end else if (gap >= thr.dash_min && gap < thr.letter_min) begin
        add_symbol(1);
      end else if (gap >= thr.letter_min && gap < thr.word_min) begin
        if (has_letter) due_chars.push_back(char_word_t'{take_letter(), 1'b1});
      end else if (gap >= thr.word_min) begin
        if (has_letter) due_chars.push_back(char_word_t'{take_letter(), 1'b0});
        due_chars.push_back(char_word_t'{CH_SPACE, 1'b1});
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] got_code, logic got_last);
      char_word_t want;
      if (due_chars.size() == 0) begin
        $error("Unexpected result word: char_code %0d, last %0b", got_code, got_last);
        errors++;
        return;
      end
      want = due_chars.pop_front();
      if (got_code !== want.char_code) begin
        $error("char_code: expected %0d, actual %0d", want.char_code, got_code);
        errors++;
      end
      if (got_last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got_last);
        errors++;
      end
      if (got_code == CH_SPACE) spaces_seen++;
      else if (got_code == CH_UNKNOWN) unknown_seen++;
      else letters_seen++;
    endfunction

    function int pending();
      return due_chars.size();
    endfunction
  endclass

  // The opening sequence runs with the reset thresholds (dot 1, dash 2,
  // letter 3, word 4). It starts two ticks below the wrap point, so the first
  // gap crosses zero. In order: a word end on an empty register (space only),
  // a letter end on an empty register (nothing), a gap below the dot range,
  // "A" closed by a letter gap, "B" closed by a word gap (letter then space),
  // four dashes that match no letter, nine dots that overrun the register,
  // closed by the largest possible gap.
  localparam int OPENING_LEN = 26;
  localparam logic [31:0] OPENING_GAPS [OPENING_LEN] = '{
    32'd4, 32'd3, 32'd0,
    32'd1, 32'd2, 32'd3,
    32'd2, 32'd1, 32'd1, 32'd1, 32'd4,
    32'd2, 32'd2, 32'd2, 32'd2, 32'd3,
    32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1,
    32'hFFFF_FFFF
  };
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int SETTLE_CYCLES = 8;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [PULSE_W-1:0]   in_pulse_time;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CHAR_W-1:0]    out_char_code;
  logic                 out_last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [THR_W-1:0]     cfg_data;

  morse_char_checker sb = new();

  // Sender bookkeeping: the stamp of the last pulse driven, the words left in
  // the current burst, and whether this phase runs without sender gaps.
  logic [31:0] gen_time = '0;
  int          burst_left = 0;
  bit          eager = 0;
  int          phase_items = 0;
  int          pulses_sent = 0;

  stall_mode_t stall_mode = STALL_NONE;
  int          stall_span = 0;
  int          stall_hold = 0;

  morse_interval_decoder uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pulse_time (in_pulse_time),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Every handshake is sampled right at the rising edge, before any of this
  // edge's updates land, so the order of processes within the step does not
  // matter. Pulses are noted first in case a result ever follows in the same
  // cycle.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_pulse(in_pulse_time);
    if (rst_n && out_valid && !out_stall) sb.check_char(out_char_code, out_last);
  end

  // The receiver switches at random between stall patterns: none at all,
  // stalls drawn at random each cycle, long holds and a strict toggle.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(STALL_NONE, STALL_TOGGLE));
      stall_span <= $urandom_range(20, 200);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 9) < 3);
      STALL_LONG: begin
        if (stall_hold == 0) begin
          out_stall <= !out_stall;
          stall_hold <= $urandom_range(1, 20);
        end else begin
          stall_hold <= stall_hold - 1;
        end
      end
      default: out_stall <= stall_span[0];
    endcase
  end

  // Drives one pulse and returns at the edge that accepts it, leaving valid
  // high so back-to-back pulses follow without a gap. Bursts of random length
  // are separated by random gaps unless the phase is eager.
  task automatic drive_pulse(input logic [31:0] stamp);
    int pause;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      pause = eager ? 0 : $urandom_range(0, 12);
      if (pause != 0) begin
        in_valid <= 1'b0;
        repeat (pause) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_pulse_time <= stamp;
    do @(posedge clk); while (in_stall);
    pulses_sent++;
  endtask

  // Picks a gap in [lo, hi], leaning on the two ends of the range. An empty
  // range, which inconsistent thresholds can produce, gives any gap at all.
  function automatic logic [31:0] pick_gap(longint lo, longint hi);
    longint span;
    if (hi < lo) return $urandom;
    span = hi - lo;
    case ($urandom_range(0, 3))
      0: return lo[31:0];
      1: return hi[31:0];
      2: return lo[31:0] + $urandom_range(0, 32'(span < 40 ? span : 40));
      default: return lo[31:0] + $urandom_range(0, 32'(span));
    endcase
  endfunction

  // Sends the next pulse after a gap of the requested class under the
  // thresholds currently programmed. GAP_NONE means below the dot range.
  task automatic send_class(input gap_class_t cls);
    longint lo;
    longint hi;
    lo = 0;
    hi = -1;
    case (cls)
      GAP_DOT: begin
        lo = sb.thr.dot_min;
        hi = longint'(sb.thr.dash_min) - 1;
      end
      GAP_DASH: begin
        lo = sb.thr.dash_min;
        hi = longint'(sb.thr.letter_min) - 1;
      end
      GAP_LETTER: begin
        lo = sb.thr.letter_min;
        hi = longint'(sb.thr.word_min) - 1;
      end
      GAP_WORD: begin
        lo = sb.thr.word_min;
        hi = 32'hFFFF_FFFF;
      end
      default: hi = longint'(sb.thr.dot_min) - 1;
    endcase
    gen_time = gen_time + pick_gap(lo, hi);
    drive_pulse(gen_time);
    if (cls != GAP_NONE) phase_items++;
  endtask

  // Holds the sender until every predicted word has arrived, then waits out
  // the pipeline in case the last pulse is still in flight without a result.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four thresholds, then one write to an unused index that the
  // block must ignore. Only called while the decoder is idle.
  task automatic program_thresholds(input logic [THR_W-1:0] dot, dash, letter, word);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [THR_W-1:0]     val [5];
    idx = '{REG_DOT_MIN, REG_DASH_MIN, REG_LETTER_MIN, REG_WORD_MIN,
            CFG_IDX_W'($urandom_range(int'(REG_WORD_MIN) + 1, 255))};
    val = '{dot, dash, letter, word, THR_W'($urandom)};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    string       pattern;
    int          run_kind;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pulse_time = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening under the reset thresholds.
    gen_time = 32'hFFFF_FFFE;
    drive_pulse(gen_time);
    for (int i = 0; i < OPENING_LEN; i++) begin
      gen_time = gen_time + OPENING_GAPS[i];
      drive_pulse(gen_time);
    end
    wait_for_results();

    // Random phases. Phase 0 keeps the reset thresholds; the next ones cover
    // the extremes and some realistic timings; the last ones are random, with
    // odd phases ordered and even phases unordered.
    for (int phase = 0; phase < PHASES; phase++) begin
      a = 16'($urandom_range(0, 20));
      b = a + 16'($urandom_range(0, 40));
      c = b + 16'($urandom_range(0, 80));
      case (phase)
        0: ;
        1: program_thresholds(16'd0, 16'd0, 16'd0, 16'd0);
        2: program_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: program_thresholds(16'd0, 16'd1, 16'd2, 16'd3);
        4: program_thresholds(16'd10, 16'd30, 16'd70, 16'd150);
        5: program_thresholds(16'd200, 16'd3000, 16'd9000, 16'd40000);
        6: program_thresholds(16'hFFFC, 16'hFFFD, 16'hFFFE, 16'hFFFF);
        7: program_thresholds(16'd1, 16'd2, 16'd3, 16'hFFFF);
        default: begin
          if (phase % 2 == 1) begin
            program_thresholds(a, b, c, c + 16'($urandom_range(0, 200)));
          end else begin
            program_thresholds(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
          end
        end
      endcase
      eager = ($urandom_range(0, 3) == 0);
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 4) != 0) begin
          // A well-formed letter: a real code, an empty one, or a random run
          // long enough to miss the table or overrun the register.
          run_kind = $urandom_range(0, 9);
          if (run_kind == 1) begin
            repeat ($urandom_range(5, 11)) send_class($urandom_range(0, 1) ? GAP_DASH : GAP_DOT);
          end else if (run_kind != 0) begin
            pattern = morse_char_checker::morse_of($urandom_range(0, NLETTERS - 1));
            for (int i = 0; i < pattern.len(); i++) begin
              send_class(pattern[i] == "-" ? GAP_DASH : GAP_DOT);
            end
          end
          send_class($urandom_range(0, 2) != 0 ? GAP_LETTER : GAP_WORD);
        end else begin
          // Noise: gaps below the dot range, stray classes, or a jump to
          // an arbitrary stamp.
          case ($urandom_range(0, 2))
            0: send_class(GAP_NONE);
            1: send_class(gap_class_t'($urandom_range(GAP_NONE, GAP_WORD)));
            default: begin
              gen_time = $urandom;
              drive_pulse(gen_time);
              phase_items++;
            end
          endcase
        end
        if ($urandom_range(0, 199) == 0) wait_for_results();
      end
      wait_for_results();
    end

    $display("Sent %0d pulses over the reset thresholds and %0d programmed settings.",
             pulses_sent, PHASES - 1);
    $display("Checked %0d letters, %0d unknown marks and %0d word spaces.",
             sb.letters_seen, sb.unknown_seen, sb.spaces_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: filelist.f
design/mid_pkg.sv
design/mid_front.sv
design/mid_queue.sv
design/mid_back.sv
design/morse_interval_decoder.sv
tb/morse_interval_decoder_test.sv
